// File: sv/irfm_pkg.sv
// Package for the interrupt rate flow monitor.
// Event, status, phase and register codes, limits and shared types.
// No dependencies.
`default_nettype none

package irfm_pkg;

    localparam int unsigned CNT_W   = 16;
    localparam int unsigned SLOW_W  = 8;
    localparam int unsigned TIMER_W = 32;
    localparam int unsigned FAIL_W  = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [FAIL_W-1:0] FAIL_LIMIT = 4'd10;
    localparam logic [CNT_W-1:0]  WDG_WINDOW = 16'd100;

    localparam logic [1:0] CMD_FAST  = 2'd0;
    localparam logic [1:0] CMD_MID   = 2'd1;
    localparam logic [1:0] CMD_SLOW  = 2'd2;
    localparam logic [1:0] CMD_CHECK = 2'd3;

    localparam logic [2:0] ST_INIT    = 3'd0;
    localparam logic [2:0] ST_VALID   = 3'd1;
    localparam logic [2:0] ST_RANGE   = 3'd2;
    localparam logic [2:0] ST_OVF     = 3'd3;
    localparam logic [2:0] ST_LIMIT   = 3'd4;
    localparam logic [2:0] ST_INVALID = 3'd5;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_RUN    = 2'd1;
    localparam logic [1:0] PH_FAILED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FAST_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MID_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MID_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MAX = 3'd7;

    typedef logic [1:0]            t_cmd;
    typedef logic [2:0]            t_status;
    typedef logic [FAIL_W-1:0]     t_fail;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [SLOW_W-1:0]     t_slow;
    typedef logic [TIMER_W-1:0]    t_timer;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    typedef struct packed {
        t_cnt   fast_min;
        t_cnt   fast_max;
        t_cnt   mid_min;
        t_cnt   mid_max;
        t_slow  slow_min;
        t_slow  slow_max;
        t_timer period_min;
        t_timer period_max;
    } t_cfg;

    typedef struct packed {
        t_timer diff;
        logic   all_sat;
        logic   in_window;
    } t_chk;

endpackage

`default_nettype wire

// File: sv/irfm_in_if.sv
// Event input channel of the flow monitor.
// Depends on irfm_pkg.
`default_nettype none

interface irfm_in_if;
    import irfm_pkg::*;

    logic   valid;
    logic   ready;
    t_cmd   cmd;
    t_timer timer_sample;

    modport source (output valid, output cmd, output timer_sample, input ready);
    modport sink   (input valid, input cmd, input timer_sample, output ready);
endinterface

`default_nettype wire

// File: sv/irfm_out_if.sv
// Result output channel of the flow monitor.
// Depends on irfm_pkg.
`default_nettype none

interface irfm_out_if;
    import irfm_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    logic    wdg_trigger;
    logic    halt_request;
    t_fail   failure_count;
    t_cnt    captured_fast;
    t_cnt    captured_mid;
    t_slow   captured_slow;
    t_timer  period_diff;

    modport source (output valid, output status, output wdg_trigger, output halt_request,
                    output failure_count, output captured_fast, output captured_mid,
                    output captured_slow, output period_diff, input ready);
    modport sink   (input valid, input status, input wdg_trigger, input halt_request,
                    input failure_count, input captured_fast, input captured_mid,
                    input captured_slow, input period_diff, output ready);
endinterface

`default_nettype wire

// File: sv/irfm_cfg_if.sv
// Configuration write channel of the flow monitor.
// Depends on irfm_pkg.
`default_nettype none

interface irfm_cfg_if;
    import irfm_pkg::*;

    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/interrupt_rate_flow_monitor.sv
// Interrupt rate flow monitor: one result per event, one beat per cycle unless stalled.
// An event is decoded against the held state in the cycle it is accepted and its
// result lands in the output register in the next cycle. Input ready is high while
// the output register is empty or being drained, so the rate is set only by the
// output side's ready. Configuration writes take effect at once and are always ready.
// Depends on irfm_pkg, irfm_in_if, irfm_out_if, irfm_cfg_if and irfm_check.
`default_nettype none

module interrupt_rate_flow_monitor (
    input  wire         i_clk,
    input  wire         i_rst_n,
    irfm_in_if.sink     i_in,
    irfm_out_if.source  o_out,
    irfm_cfg_if.sink    i_cfg
);
    import irfm_pkg::*;

    t_cfg    r_cfg;
    logic [1:0] r_phase, n_phase;
    t_status r_status, n_status;
    t_fail   r_fail_cnt, n_fail_cnt;
    t_cnt    r_fast_cnt, n_fast_cnt;
    t_cnt    r_mid_cnt, n_mid_cnt;
    t_slow   r_slow_cnt, n_slow_cnt;
    t_cnt    r_fast_snap, n_fast_snap;
    t_cnt    r_mid_snap, n_mid_snap;
    t_slow   r_slow_snap, n_slow_snap;
    t_timer  r_timer_latest, n_timer_latest;
    t_timer  r_diff, n_diff;
    logic    n_trig, n_halt;

    logic    r_out_valid;
    t_status r_out_status;
    logic    r_out_trig;
    logic    r_out_halt;
    t_fail   r_out_fail;
    t_cnt    r_out_fast;
    t_cnt    r_out_mid;
    t_slow   r_out_slow;
    t_timer  r_out_diff;

    logic    w_accept;
    t_chk    w_chk;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_accept    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    irfm_check u_check (
        .i_cfg    (r_cfg),
        .i_fast   (r_fast_cnt),
        .i_mid    (r_mid_cnt),
        .i_slow   (r_slow_cnt),
        .i_sample (i_in.timer_sample),
        .i_prev   (r_timer_latest),
        .o_chk    (w_chk)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_min   <= 16'd400;
            r_cfg.fast_max   <= 16'd935;
            r_cfg.mid_min    <= 16'd60;
            r_cfg.mid_max    <= 16'd140;
            r_cfg.slow_min   <= 8'd6;
            r_cfg.slow_max   <= 8'd14;
            r_cfg.period_min <= 32'd37500;
            r_cfg.period_max <= 32'd87500;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_FAST_MIN:   r_cfg.fast_min   <= i_cfg.data[CNT_W-1:0];
                REG_FAST_MAX:   r_cfg.fast_max   <= i_cfg.data[CNT_W-1:0];
                REG_MID_MIN:    r_cfg.mid_min    <= i_cfg.data[CNT_W-1:0];
                REG_MID_MAX:    r_cfg.mid_max    <= i_cfg.data[CNT_W-1:0];
                REG_SLOW_MIN:   r_cfg.slow_min   <= i_cfg.data[SLOW_W-1:0];
                REG_SLOW_MAX:   r_cfg.slow_max   <= i_cfg.data[SLOW_W-1:0];
                REG_PERIOD_MIN: r_cfg.period_min <= i_cfg.data[TIMER_W-1:0];
                REG_PERIOD_MAX: r_cfg.period_max <= i_cfg.data[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_status       = r_status;
        n_fail_cnt     = r_fail_cnt;
        n_fast_cnt     = r_fast_cnt;
        n_mid_cnt      = r_mid_cnt;
        n_slow_cnt     = r_slow_cnt;
        n_fast_snap    = r_fast_snap;
        n_mid_snap     = r_mid_snap;
        n_slow_snap    = r_slow_snap;
        n_timer_latest = r_timer_latest;
        n_diff         = r_diff;
        n_trig         = 1'b0;
        n_halt         = 1'b0;

        case (i_in.cmd)
            CMD_FAST: begin
                if (r_phase == PH_RUN && !(&r_fast_cnt)) begin
                    n_fast_cnt = r_fast_cnt + 16'd1;
                end
            end
            CMD_MID: begin
                // decision uses the count before this tick
                if (r_status == ST_LIMIT) begin
                    n_halt = 1'b1;
                end else if (r_mid_cnt < WDG_WINDOW) begin
                    n_trig = (r_status == ST_VALID);
                end else if (r_mid_cnt > WDG_WINDOW) begin
                    n_status = ST_INVALID;
                end
                if (r_phase == PH_RUN && !(&r_mid_cnt)) begin
                    n_mid_cnt = r_mid_cnt + 16'd1;
                end
            end
            CMD_SLOW: begin
                if (r_phase == PH_RUN && !(&r_slow_cnt)) begin
                    n_slow_cnt = r_slow_cnt + 8'd1;
                end
            end
            CMD_CHECK: begin
                case (r_phase)
                    PH_RUN: begin
                        n_timer_latest = i_in.timer_sample;
                        n_status       = ST_INIT;
                        if (r_fail_cnt == FAIL_LIMIT) begin
                            n_status = ST_LIMIT;
                            n_phase  = PH_FAILED;
                        end else if (w_chk.all_sat) begin
                            n_status   = ST_OVF;
                            n_fail_cnt = r_fail_cnt + 4'd1;
                        end else begin
                            n_fast_snap = r_fast_cnt;
                            n_mid_snap  = r_mid_cnt;
                            n_slow_snap = r_slow_cnt;
                            n_fast_cnt  = '0;
                            n_mid_cnt   = '0;
                            n_slow_cnt  = '0;
                            n_diff      = w_chk.diff;
                            if (w_chk.in_window) begin
                                n_status = ST_VALID;
                            end else begin
                                n_status   = ST_RANGE;
                                n_fail_cnt = r_fail_cnt + 4'd1;
                            end
                        end
                    end
                    PH_FIRST: begin
                        n_status       = ST_INIT;
                        n_fail_cnt     = '0;
                        n_timer_latest = i_in.timer_sample;
                    end
                    default: ;
                endcase
                if (n_status != ST_VALID && n_status != ST_LIMIT) begin
                    n_fast_cnt  = '0;
                    n_mid_cnt   = '0;
                    n_slow_cnt  = '0;
                    n_fast_snap = '0;
                    n_mid_snap  = '0;
                    n_slow_snap = '0;
                    n_phase     = PH_RUN;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_FIRST;
            r_status       <= ST_INIT;
            r_fail_cnt     <= '0;
            r_fast_cnt     <= '0;
            r_mid_cnt      <= '0;
            r_slow_cnt     <= '0;
            r_fast_snap    <= '0;
            r_mid_snap     <= '0;
            r_slow_snap    <= '0;
            r_timer_latest <= '0;
            r_diff         <= '0;
        end else if (w_accept) begin
            r_phase        <= n_phase;
            r_status       <= n_status;
            r_fail_cnt     <= n_fail_cnt;
            r_fast_cnt     <= n_fast_cnt;
            r_mid_cnt      <= n_mid_cnt;
            r_slow_cnt     <= n_slow_cnt;
            r_fast_snap    <= n_fast_snap;
            r_mid_snap     <= n_mid_snap;
            r_slow_snap    <= n_slow_snap;
            r_timer_latest <= n_timer_latest;
            r_diff         <= n_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_status <= n_status;
            r_out_trig   <= n_trig;
            r_out_halt   <= n_halt;
            r_out_fail   <= n_fail_cnt;
            r_out_fast   <= n_fast_snap;
            r_out_mid    <= n_mid_snap;
            r_out_slow   <= n_slow_snap;
            r_out_diff   <= n_diff;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.wdg_trigger   = r_out_trig;
    assign o_out.halt_request  = r_out_halt;
    assign o_out.failure_count = r_out_fail;
    assign o_out.captured_fast = r_out_fast;
    assign o_out.captured_mid  = r_out_mid;
    assign o_out.captured_slow = r_out_slow;
    assign o_out.period_diff   = r_out_diff;

    a_failed_holds_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FAILED) |-> (r_status == ST_LIMIT))
        else $error("failed phase without limit status");

    a_fail_cnt_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fail_cnt <= FAIL_LIMIT)
        else $error("failure count above limit");

    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("event taken while result stalled");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out.valid)
        else $error("accepted event produced no result");

endmodule

`default_nettype wire

// File: sv/irfm_check.sv
// Check evaluation: wrapped timer difference, saturation test and window tests.
// Depends on irfm_pkg.
`default_nettype none

module irfm_check (
    input  irfm_pkg::t_cfg   i_cfg,
    input  irfm_pkg::t_cnt   i_fast,
    input  irfm_pkg::t_cnt   i_mid,
    input  irfm_pkg::t_slow  i_slow,
    input  irfm_pkg::t_timer i_sample,
    input  irfm_pkg::t_timer i_prev,
    output irfm_pkg::t_chk   o_chk
);
    import irfm_pkg::*;

    t_timer w_diff;
    logic   w_fast_ok;
    logic   w_mid_ok;
    logic   w_slow_ok;
    logic   w_period_ok;

    // equal samples wrap to all ones
    assign w_diff = (i_sample > i_prev) ? (i_sample - i_prev) : (~i_prev + i_sample);

    assign w_fast_ok   = (i_cfg.fast_min < i_fast) && (i_fast < i_cfg.fast_max);
    assign w_mid_ok    = (i_cfg.mid_min < i_mid) && (i_mid < i_cfg.mid_max);
    assign w_slow_ok   = (i_cfg.slow_min < i_slow) && (i_slow < i_cfg.slow_max);
    assign w_period_ok = (i_cfg.period_min < w_diff) && (w_diff < i_cfg.period_max);

    assign o_chk.diff      = w_diff;
    assign o_chk.all_sat   = (&i_fast) && (&i_mid) && (&i_slow);
    assign o_chk.in_window = w_fast_ok && w_mid_ok && w_slow_ok && w_period_ok;

endmodule

`default_nettype wire
